// ----- design/bb3_pkg.sv -----
`default_nettype none

package bb3_pkg;

   // Default frame limits, handed to the top level parameters
   localparam int DEFAULT_MAX_WIDTH = 1024;
   localparam int DEFAULT_MAX_HEIGHT = 4096;

   // Pixel and arithmetic widths
   localparam int CHANNEL_BITS = 8;
   localparam int PIXEL_BITS = 3 * CHANNEL_BITS;
   localparam int LINE_BITS = 2 * PIXEL_BITS;
   localparam int SUM_BITS = 12;
   localparam int COUNT_BITS = 4;
   localparam int NUMER_BITS = SUM_BITS + 1;
   localparam int RECIP_BITS = 18;
   localparam int RECIP_SHIFT = 18;
   localparam int PRODUCT_BITS = NUMER_BITS + RECIP_BITS;

   // Register file
   localparam int WIDTH_REG_BITS = 11;
   localparam int HEIGHT_REG_BITS = 13;
   localparam int CSR_DATA_BITS = 13;
   localparam int CSR_INDEX_BITS = 1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_WIDTH = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_HEIGHT = 1'b1;
   localparam logic [WIDTH_REG_BITS-1:0] WIDTH_RESET = 11'd1024;
   localparam logic [HEIGHT_REG_BITS-1:0] HEIGHT_RESET = 13'd768;

   // Which neighbors of the current output lie inside the frame
   typedef struct packed {
      logic       due;
      logic       last;
      logic [2:0] row_mask;
      logic [2:0] col_mask;
   } tap_ctrl_type;

   // Per-channel neighborhood sums heading for the divider
   typedef struct packed {
      logic                  valid;
      logic                  last;
      logic [SUM_BITS-1:0]   sum_red;
      logic [SUM_BITS-1:0]   sum_green;
      logic [SUM_BITS-1:0]   sum_blue;
      logic [COUNT_BITS-1:0] count;
   } sum_type;

   // ceil(2^18 / (2*count)); exact floor division for numerators below 4600
   function automatic logic [RECIP_BITS-1:0] recip_of(input logic [COUNT_BITS-1:0] count);
      logic [RECIP_BITS-1:0] recip;
      case (count)
         4'd1:    recip = 18'd131072;
         4'd2:    recip = 18'd65536;
         4'd3:    recip = 18'd43691;
         4'd4:    recip = 18'd32768;
         4'd5:    recip = 18'd26215;
         4'd6:    recip = 18'd21846;
         4'd7:    recip = 18'd18725;
         4'd8:    recip = 18'd16384;
         4'd9:    recip = 18'd14564;
         default: recip = '0;
      endcase
      return recip;
   endfunction

endpackage

`default_nettype wire

// ----- design/box_blur_3x3_rgb.sv -----
// 3x3 box blur over an RGB stream, mean taken over in-frame neighbors only.
// Requests carry one pixel each in raster order (req_mode 0) or a flush item
// (req_mode 1, pixel fields ignored, stored as black). After the last pixel
// of a frame the sender supplies image_width+1 flush requests to drain it.
// Each request after the first row and one pixel yields one response; the
// response with rsp_frame_last set closes the frame and restarts counting.
// Both channels move a request at a clock edge with valid high, stall low.
// Throughput: one request per clock unless a held response stalls it, set by
// the single line store read-modify-write of one column per request.
// The request that completes a neighborhood (one row plus one pixel after
// its pixel) passes stage 1, window sums, product and output registers.
// The csr port writes image_width (index 0) and image_height (index 1) with
// no wait; write them only while the block is idle.
// Reset clears counters, window and pipeline, holds req_stall high and loads
// 1024 x 768. The line store is not cleared; unwritten columns are never used
// in a frame.
// While a response waits with rsp_stall high the whole pipeline holds and
// req_stall is raised in the same cycle.
`default_nettype none

module box_blur_3x3_rgb #(
   parameter int MAX_WIDTH = bb3_pkg::DEFAULT_MAX_WIDTH,
   parameter int MAX_HEIGHT = bb3_pkg::DEFAULT_MAX_HEIGHT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic                                 req_mode,
   input  wire logic [bb3_pkg::CHANNEL_BITS-1:0]     req_pixel_red,
   input  wire logic [bb3_pkg::CHANNEL_BITS-1:0]     req_pixel_green,
   input  wire logic [bb3_pkg::CHANNEL_BITS-1:0]     req_pixel_blue,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic [bb3_pkg::CHANNEL_BITS-1:0]          rsp_blurred_red,
   output logic [bb3_pkg::CHANNEL_BITS-1:0]          rsp_blurred_green,
   output logic [bb3_pkg::CHANNEL_BITS-1:0]          rsp_blurred_blue,
   output logic                                      rsp_frame_last,
   input  wire logic                                 csr_write_enable,
   input  wire logic [bb3_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [bb3_pkg::CSR_DATA_BITS-1:0]    csr_write_data
);
   import bb3_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int RW = $clog2(MAX_HEIGHT);
   localparam int HW = $clog2(MAX_HEIGHT + 1);

   localparam logic MODE_FLUSH = 1'b1;

   // Input row phase: first row, second row, third row onward
   localparam logic [1:0] PHASE_FIRST = 2'd0;
   localparam logic [1:0] PHASE_SECOND = 2'd1;
   localparam logic [1:0] PHASE_STEADY = 2'd2;

   logic [WIDTH_REG_BITS-1:0]  image_width_ff;
   logic [HEIGHT_REG_BITS-1:0] image_height_ff;
   logic [WW-1:0]              width_eff;
   logic [HW-1:0]              height_eff;

   logic [CW-1:0] in_col_ff;
   logic [CW-1:0] in_col_in;
   logic [1:0]    in_phase_ff;
   logic [1:0]    in_phase_in;
   logic [RW-1:0] out_row_ff;
   logic [RW-1:0] out_row_in;
   logic [CW-1:0] out_col_ff;
   logic [CW-1:0] out_col_in;

   logic                  accept;
   logic                  advance;
   logic [PIXEL_BITS-1:0] pixel;
   tap_ctrl_type          ctrl_in;

   logic                  s1_valid_ff;
   logic [PIXEL_BITS-1:0] s1_pix_ff;
   logic [CW-1:0]         s1_addr_ff;
   tap_ctrl_type          s1_ctrl_ff;

   logic                  line_wr_en;
   logic [LINE_BITS-1:0]  line_wr_data;
   logic [LINE_BITS-1:0]  line_rd_data;
   sum_type               sums;

   // Whole pipeline moves unless a response is held
   assign advance = !rsp_valid || !rsp_stall;
   assign req_stall = !advance || reset;
   assign accept = req_valid && !req_stall;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff <= WIDTH_RESET;
         image_height_ff <= HEIGHT_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  image_width_ff <= csr_write_data[WIDTH_REG_BITS-1:0];
            CSR_IMAGE_HEIGHT: image_height_ff <= csr_write_data[HEIGHT_REG_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Frame size clamped to 1..MAX
   always_comb begin
      if (image_width_ff == '0) begin
         width_eff = WW'(1);
      end else if (32'(image_width_ff) > 32'(MAX_WIDTH)) begin
         width_eff = WW'(MAX_WIDTH);
      end else begin
         width_eff = WW'(image_width_ff);
      end
      if (image_height_ff == '0) begin
         height_eff = HW'(1);
      end else if (32'(image_height_ff) > 32'(MAX_HEIGHT)) begin
         height_eff = HW'(MAX_HEIGHT);
      end else begin
         height_eff = HW'(image_height_ff);
      end
   end

   // Neighbor masks, frame end and counter update
   always_comb begin
      ctrl_in.due = (in_phase_ff == PHASE_STEADY) ||
                    ((in_phase_ff == PHASE_SECOND) && (in_col_ff != '0));
      ctrl_in.row_mask[0] = (out_row_ff != '0) && (HW'(out_row_ff) <= height_eff);
      ctrl_in.row_mask[1] = HW'(out_row_ff) < height_eff;
      ctrl_in.row_mask[2] = (HW'(out_row_ff) + HW'(1)) < height_eff;
      ctrl_in.col_mask[0] = (out_col_ff != '0) && (WW'(out_col_ff) <= width_eff);
      ctrl_in.col_mask[1] = WW'(out_col_ff) < width_eff;
      // at a row start the right column already belongs to the next row
      ctrl_in.col_mask[2] = ((WW'(out_col_ff) + WW'(1)) < width_eff) && (in_col_ff != '0);
      ctrl_in.last = ((HW'(out_row_ff) + HW'(1)) >= height_eff) &&
                     ((WW'(out_col_ff) + WW'(1)) >= width_eff);

      in_col_in = in_col_ff;
      in_phase_in = in_phase_ff;
      out_row_in = out_row_ff;
      out_col_in = out_col_ff;
      if (accept) begin
         if ((WW'(in_col_ff) + WW'(1)) >= width_eff) begin
            in_col_in = '0;
            if (in_phase_ff != PHASE_STEADY) begin
               in_phase_in = in_phase_ff + 2'd1;
            end
         end else begin
            in_col_in = in_col_ff + CW'(1);
         end
         if (ctrl_in.due) begin
            if (ctrl_in.last) begin
               in_col_in = '0;
               in_phase_in = PHASE_FIRST;
               out_row_in = '0;
               out_col_in = '0;
            end else if ((WW'(out_col_ff) + WW'(1)) >= width_eff) begin
               out_col_in = '0;
               out_row_in = out_row_ff + RW'(1);
            end else begin
               out_col_in = out_col_ff + CW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff <= '0;
         in_phase_ff <= PHASE_FIRST;
         out_row_ff <= '0;
         out_col_ff <= '0;
      end else begin
         in_col_ff <= in_col_in;
         in_phase_ff <= in_phase_in;
         out_row_ff <= out_row_in;
         out_col_ff <= out_col_in;
      end
   end

   // Flush items enter as black
   assign pixel = (req_mode == MODE_FLUSH) ? '0
                : {req_pixel_red, req_pixel_green, req_pixel_blue};

   // Stage 1 waits on the line store read
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff <= pixel;
         s1_addr_ff <= in_col_ff;
         s1_ctrl_ff <= ctrl_in;
      end
   end

   // Rows move up one: newer becomes older, the request becomes newer
   assign line_wr_en = s1_valid_ff && advance;
   assign line_wr_data = {line_rd_data[PIXEL_BITS-1:0], s1_pix_ff};

   bb3_line_store #(
      .DEPTH (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (in_col_ff),
      .wr_en   (line_wr_en),
      .wr_addr (s1_addr_ff),
      .wr_data (line_wr_data),
      .rd_data (line_rd_data)
   );

   bb3_window u_window (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .in_valid    (s1_valid_ff),
      .older_pixel (line_rd_data[LINE_BITS-1:PIXEL_BITS]),
      .newer_pixel (line_rd_data[PIXEL_BITS-1:0]),
      .new_pixel   (s1_pix_ff),
      .ctrl        (s1_ctrl_ff),
      .sums        (sums)
   );

   bb3_divide u_divide (
      .clock             (clock),
      .reset             (reset),
      .advance           (advance),
      .sums              (sums),
      .rsp_valid         (rsp_valid),
      .rsp_blurred_red   (rsp_blurred_red),
      .rsp_blurred_green (rsp_blurred_green),
      .rsp_blurred_blue  (rsp_blurred_blue),
      .rsp_frame_last    (rsp_frame_last)
   );

endmodule

`default_nettype wire

// ----- design/bb3_line_store.sv -----
`default_nettype none

module bb3_line_store #(
   parameter int DEPTH = bb3_pkg::DEFAULT_MAX_WIDTH
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           rd_en,
   input  wire logic [$clog2(DEPTH)-1:0]       rd_addr,
   input  wire logic                           wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]       wr_addr,
   input  wire logic [bb3_pkg::LINE_BITS-1:0]  wr_data,
   output logic [bb3_pkg::LINE_BITS-1:0]       rd_data
);
   import bb3_pkg::*;

   // Each entry holds {older row pixel, newer row pixel} of one column
   logic [LINE_BITS-1:0] ram [DEPTH];
   logic [LINE_BITS-1:0] ram_q_ff;
   logic                 bypass_ff;
   logic [LINE_BITS-1:0] bypass_data_ff;

   // Single port pair, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         ram[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         ram_q_ff <= ram[rd_addr];
      end
   end

   // Same-column write in the read cycle: hand the new data over
   always_ff @(posedge clock) begin
      if (reset) begin
         bypass_ff <= 1'b0;
      end else if (rd_en) begin
         bypass_ff <= wr_en && (rd_addr == wr_addr);
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         bypass_data_ff <= wr_data;
      end
   end

   assign rd_data = bypass_ff ? bypass_data_ff : ram_q_ff;

endmodule

`default_nettype wire

// ----- design/bb3_window.sv -----
`default_nettype none

module bb3_window (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            advance,
   input  wire logic                            in_valid,
   input  wire logic [bb3_pkg::PIXEL_BITS-1:0]  older_pixel,
   input  wire logic [bb3_pkg::PIXEL_BITS-1:0]  newer_pixel,
   input  wire logic [bb3_pkg::PIXEL_BITS-1:0]  new_pixel,
   input  wire bb3_pkg::tap_ctrl_type           ctrl,
   output bb3_pkg::sum_type                     sums
);
   import bb3_pkg::*;

   // Row 0 is the oldest row, column 2 the newest column
   logic [PIXEL_BITS-1:0] win_ff [3][3];
   logic [PIXEL_BITS-1:0] win_in [3][3];
   logic [PIXEL_BITS-1:0] new_col [3];
   sum_type               sums_ff;
   sum_type               sums_in;

   // Shift in the new column
   always_comb begin
      new_col[0] = older_pixel;
      new_col[1] = newer_pixel;
      new_col[2] = new_pixel;
      for (int i = 0; i < 3; i++) begin
         win_in[i][0] = win_ff[i][1];
         win_in[i][1] = win_ff[i][2];
         win_in[i][2] = new_col[i];
      end
   end

   // Masked sums over the shifted window
   always_comb begin
      sums_in = '0;
      sums_in.valid = in_valid && ctrl.due;
      sums_in.last = ctrl.last;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            if (ctrl.row_mask[i] && ctrl.col_mask[j]) begin
               sums_in.sum_red = sums_in.sum_red + SUM_BITS'(win_in[i][j][23:16]);
               sums_in.sum_green = sums_in.sum_green + SUM_BITS'(win_in[i][j][15:8]);
               sums_in.sum_blue = sums_in.sum_blue + SUM_BITS'(win_in[i][j][7:0]);
               sums_in.count = sums_in.count + COUNT_BITS'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               win_ff[i][j] <= '0;
            end
         end
      end else if (advance && in_valid) begin
         win_ff <= win_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sums_ff.valid <= 1'b0;
      end else if (advance) begin
         sums_ff <= sums_in;
      end
   end

   assign sums = sums_ff;

endmodule

`default_nettype wire

// ----- design/bb3_divide.sv -----
`default_nettype none

module bb3_divide (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              advance,
   input  wire bb3_pkg::sum_type                  sums,
   output logic                                   rsp_valid,
   output logic [bb3_pkg::CHANNEL_BITS-1:0]       rsp_blurred_red,
   output logic [bb3_pkg::CHANNEL_BITS-1:0]       rsp_blurred_green,
   output logic [bb3_pkg::CHANNEL_BITS-1:0]       rsp_blurred_blue,
   output logic                                   rsp_frame_last
);
   import bb3_pkg::*;

   logic                    prod_valid_ff;
   logic                    prod_last_ff;
   logic [PRODUCT_BITS-1:0] prod_red_ff;
   logic [PRODUCT_BITS-1:0] prod_green_ff;
   logic [PRODUCT_BITS-1:0] prod_blue_ff;
   logic [PRODUCT_BITS-1:0] prod_red_in;
   logic [PRODUCT_BITS-1:0] prod_green_in;
   logic [PRODUCT_BITS-1:0] prod_blue_in;
   logic [NUMER_BITS-1:0]   numer_red;
   logic [NUMER_BITS-1:0]   numer_green;
   logic [NUMER_BITS-1:0]   numer_blue;
   logic [RECIP_BITS-1:0]   recip;
   logic                    rsp_valid_ff;
   logic [CHANNEL_BITS-1:0] red_ff;
   logic [CHANNEL_BITS-1:0] green_ff;
   logic [CHANNEL_BITS-1:0] blue_ff;
   logic                    last_ff;

   // Rounded mean: (2*sum + count) / (2*count) via reciprocal multiply
   always_comb begin
      recip = recip_of(sums.count);
      numer_red = {sums.sum_red, 1'b0} + NUMER_BITS'(sums.count);
      numer_green = {sums.sum_green, 1'b0} + NUMER_BITS'(sums.count);
      numer_blue = {sums.sum_blue, 1'b0} + NUMER_BITS'(sums.count);
      prod_red_in = PRODUCT_BITS'(numer_red) * PRODUCT_BITS'(recip);
      prod_green_in = PRODUCT_BITS'(numer_green) * PRODUCT_BITS'(recip);
      prod_blue_in = PRODUCT_BITS'(numer_blue) * PRODUCT_BITS'(recip);
   end

   // Product stage
   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
      end else if (advance) begin
         prod_valid_ff <= sums.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_last_ff <= sums.last;
         prod_red_ff <= prod_red_in;
         prod_green_ff <= prod_green_in;
         prod_blue_ff <= prod_blue_in;
      end
   end

   // Output register, holds while the receiver stalls
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= prod_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         red_ff <= prod_red_ff[RECIP_SHIFT +: CHANNEL_BITS];
         green_ff <= prod_green_ff[RECIP_SHIFT +: CHANNEL_BITS];
         blue_ff <= prod_blue_ff[RECIP_SHIFT +: CHANNEL_BITS];
         last_ff <= prod_last_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_blurred_red = red_ff;
   assign rsp_blurred_green = green_ff;
   assign rsp_blurred_blue = blue_ff;
   assign rsp_frame_last = last_ff;

endmodule

`default_nettype wire
